// ===== design/slxed_pkg.sv =====
// ----------------------------------------------------------------------------
// slxed_pkg
// Shared types and constants for the SOF/length/XOR/EOF deframer.
// ----------------------------------------------------------------------------
package slxed_pkg;

    localparam int BYTE_W = 8;
    localparam int OFF_W  = 9;
    localparam int PAT_W  = 16;

    localparam logic [PAT_W-1:0] SOF_RESET = 16'hAA55;
    localparam logic [PAT_W-1:0] EOF_RESET = 16'h0D0A;

    // configuration register indexes
    localparam logic CFG_SOF = 1'b0;
    localparam logic CFG_EOF = 1'b1;

    // request and result kinds
    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_READ  = 1'b1;
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SOF2,
        PH_TYPE,
        PH_LEN,
        PH_PAY,
        PH_CRC,
        PH_EOF1,
        PH_EOF2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_OUT,
        ST_FEED,
        ST_SCAN_RD,
        ST_SCAN_FEED,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic push;       // store the accepted byte
        logic read;       // start a ring read for a read request
        logic feed;       // advance the parser by one byte
        logic scan_src;   // parser byte comes from the ring read port
        logic scan_init;  // point the scan cursor two past the frame start
        logic scan_rd;    // read the ring at the scan cursor
        logic load_read;  // load read data into the output register
        logic flush;      // move the held frame result out as last of run
    } cmd_t;

    typedef struct packed {
        logic hit;        // parser byte completes a good frame
        logic mismatch;   // parser byte shows a bad EOF
        logic scan_end;   // scan cursor reached the write position
        logic out_free;   // output register can take a result this cycle
        logic pend_valid; // a frame result is held back
    } stat_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] frame_type;
        logic [BYTE_W-1:0] payload_length;
        logic [OFF_W-1:0]  frame_offset;
        logic [BYTE_W-1:0] read_value;
        logic              last;
    } res_t;

endpackage

// ===== design/slxed_ram.sv =====
// ----------------------------------------------------------------------------
// slxed_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slxed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/slxed_ctrl.sv =====
// ----------------------------------------------------------------------------
// slxed_ctrl
// Sequencer for push, read and EOF-error rescan of the deframer.
// ----------------------------------------------------------------------------
module slxed_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             s_tuser,
    input  slxed_pkg::stat_t stat,
    output slxed_pkg::cmd_t  cmd
);
    import slxed_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = aresetn;
                if (aresetn && s_tvalid) begin
                    if (s_tuser == REQ_READ) begin
                        cmd.read   = 1'b1;
                        state_next = ST_RD_OUT;
                    end else begin
                        cmd.push   = 1'b1;
                        state_next = ST_FEED;
                    end
                end
            end
            ST_RD_OUT: begin
                if (stat.out_free) begin
                    cmd.load_read = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_FEED: begin
                // hold while a good frame has nowhere to go
                if (!stat.hit || stat.out_free) begin
                    cmd.feed = 1'b1;
                    if (stat.mismatch) begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_SCAN_RD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SCAN_RD: begin
                if (stat.scan_end) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.scan_rd = 1'b1;
                    state_next  = ST_SCAN_FEED;
                end
            end
            ST_SCAN_FEED: begin
                // parser byte comes from the ring whether or not it advances
                cmd.scan_src = 1'b1;
                if (!(stat.hit && stat.pend_valid && !stat.out_free)) begin
                    cmd.feed   = 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_DONE: begin
                if (!stat.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/slxed_dp.sv =====
// ----------------------------------------------------------------------------
// slxed_dp
// Datapath: raw ring store, frame parser, scan cursor, held result and
// output register.
// ----------------------------------------------------------------------------
module slxed_dp #(
    parameter int RING_DEPTH = 512
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  slxed_pkg::cmd_t                     cmd,
    output slxed_pkg::stat_t                    stat,
    input  logic [slxed_pkg::BYTE_W-1:0]        in_byte,
    input  logic [slxed_pkg::OFF_W-1:0]         in_offset,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [slxed_pkg::PAT_W-1:0]         cfg_data,
    output slxed_pkg::res_t                     out_res,
    output logic                                out_valid,
    input  logic                                out_ready
);
    import slxed_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW:0] DEPTH_X = (AW+1)'(RING_DEPTH);

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] p,
                                               input logic [1:0] k);
        logic [AW:0] s;
        begin
            s = {1'b0, p} + {{(AW-1){1'b0}}, k};
            if (s >= DEPTH_X) begin
                s = s - DEPTH_X;
            end
            return s[AW-1:0];
        end
    endfunction

    // configuration
    logic [PAT_W-1:0] sof_reg;
    logic [PAT_W-1:0] eof_reg;

    // ring bookkeeping
    logic [AW-1:0]     wp_reg;
    logic [AW-1:0]     pos_reg;
    logic [AW-1:0]     cur_reg;
    logic [BYTE_W-1:0] byte_reg;

    // parser state
    phase_t            phase_reg;
    phase_t            phase_next;
    logic [BYTE_W-1:0] xor_reg,   xor_next;
    logic [BYTE_W-1:0] len_reg,   len_next;
    logic [BYTE_W-1:0] seen_reg,  seen_next;
    logic [BYTE_W-1:0] type_reg,  type_next;
    logic [AW-1:0]     start_reg, start_next;
    logic [BYTE_W-1:0] prev_reg;

    // results
    res_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;
    res_t pend_reg;
    logic pend_valid_reg;

    logic [BYTE_W-1:0] rd_data;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] fb;
    logic [AW-1:0]     fpos;
    logic              hit;
    logic              mism;
    logic              out_free;
    logic [AW-1:0]     restart;
    res_t              frame_res;
    res_t              read_res;

    assign rd_addr = cmd.scan_rd ? cur_reg : AW'(in_offset);

    slxed_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (cmd.push),
        .wr_addr (wp_reg),
        .wr_data (in_byte),
        .rd_en   (cmd.read | cmd.scan_rd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign fb      = cmd.scan_src ? rd_data : byte_reg;
    assign fpos    = cmd.scan_src ? cur_reg : pos_reg;
    assign restart = ring_add(start_reg, 2'd2);

    // one parser step on the selected byte
    always_comb begin
        phase_next = phase_reg;
        xor_next   = xor_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        type_next  = type_reg;
        start_next = start_reg;
        hit        = 1'b0;
        mism       = 1'b0;
        case (phase_reg)
            PH_HUNT: begin
                if (fb == sof_reg[15:8]) begin
                    start_next = fpos;
                    phase_next = PH_SOF2;
                end
            end
            PH_SOF2: begin
                if (fb == sof_reg[7:0]) begin
                    phase_next = PH_TYPE;
                end else if (fb == sof_reg[15:8]) begin
                    start_next = fpos;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
            PH_TYPE: begin
                type_next  = fb;
                xor_next   = fb;
                phase_next = PH_LEN;
            end
            PH_LEN: begin
                len_next   = fb;
                xor_next   = xor_reg ^ fb;
                seen_next  = '0;
                phase_next = (fb == '0) ? PH_CRC : PH_PAY;
            end
            PH_PAY: begin
                xor_next  = xor_reg ^ fb;
                seen_next = seen_reg + 1'b1;
                if (seen_next == len_reg) begin
                    phase_next = PH_CRC;
                end
            end
            PH_CRC: begin
                xor_next   = xor_reg ^ fb;
                phase_next = PH_EOF1;
            end
            PH_EOF1: begin
                phase_next = PH_EOF2;
            end
            PH_EOF2: begin
                phase_next = PH_HUNT;
                if (prev_reg != eof_reg[15:8] || fb != eof_reg[7:0]) begin
                    mism = 1'b1;
                end else if (xor_reg == '0) begin
                    hit = 1'b1;
                end
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_comb begin
        frame_res                = '0;
        frame_res.kind           = KIND_FRAME;
        frame_res.frame_type     = type_reg;
        frame_res.payload_length = len_reg;
        frame_res.frame_offset   = start_reg[OFF_W-1:0];

        read_res            = '0;
        read_res.kind       = KIND_READ;
        read_res.read_value = rd_data;
        read_res.last       = 1'b1;
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.load_read) begin
            out_next       = read_res;
            out_valid_next = 1'b1;
        end
        if (cmd.feed && hit && !cmd.scan_src) begin
            out_next       = frame_res;
            out_next.last  = 1'b1;
            out_valid_next = 1'b1;
        end
        // a newer frame pushes the held one out as not last
        if (cmd.feed && hit && cmd.scan_src && pend_valid_reg) begin
            out_next       = pend_reg;
            out_valid_next = 1'b1;
        end
        if (cmd.flush) begin
            out_next       = pend_reg;
            out_next.last  = 1'b1;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sof_reg        <= SOF_RESET;
            eof_reg        <= EOF_RESET;
            wp_reg         <= '0;
            phase_reg      <= PH_HUNT;
            xor_reg        <= '0;
            len_reg        <= '0;
            seen_reg       <= '0;
            type_reg       <= '0;
            start_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_SOF) begin
                    sof_reg <= cfg_data;
                end else begin
                    eof_reg <= cfg_data;
                end
            end
            if (cmd.push) begin
                wp_reg <= ring_add(wp_reg, 2'd1);
            end
            if (cmd.feed) begin
                phase_reg <= phase_next;
                xor_reg   <= xor_next;
                len_reg   <= len_next;
                seen_reg  <= seen_next;
                type_reg  <= type_next;
                start_reg <= start_next;
            end
            out_valid_reg <= out_valid_next;
            if (cmd.feed && hit && cmd.scan_src) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            byte_reg <= in_byte;
            pos_reg  <= wp_reg;
        end
        if (cmd.feed) begin
            prev_reg <= fb;
        end
        if (cmd.scan_init) begin
            cur_reg <= restart;
        end else if (cmd.feed && cmd.scan_src) begin
            // restart two past the newest frame start on a bad EOF
            cur_reg <= mism ? restart : ring_add(cur_reg, 2'd1);
        end
        if (cmd.feed && hit && cmd.scan_src) begin
            pend_reg <= frame_res;
        end
        out_reg <= out_next;
    end

    assign stat.hit        = hit;
    assign stat.mismatch   = mism;
    assign stat.scan_end   = (cur_reg == wp_reg);
    assign stat.out_free   = out_free;
    assign stat.pend_valid = pend_valid_reg;

    assign out_res   = out_reg;
    assign out_valid = out_valid_reg;

endmodule

// ===== design/sof_len_xor_eof_deframer_unit.sv =====
// Push beat: store, then parse; a frame result is loaded into the output register by the parse step.
// Read beat: ring read port, then output register.
// Bad EOF: input holds while the rescan walks the ring, reading then parsing each stored byte.
// Output register decouples the sides; a stalled m_tready holds only result-producing steps.
// Reset (aresetn low, synchronous): patterns to defaults, parser hunting, position zero.
// Ring contents are not cleared; no clearing pass.
// ----------------------------------------------------------------------------
// sof_len_xor_eof_deframer_unit
// Byte-stream deframer: SOF(2), type, length, payload, XOR checksum, EOF(2),
// with a raw ring store and read-back of stored bytes.
// ----------------------------------------------------------------------------
module sof_len_xor_eof_deframer_unit #(
    parameter int RING_DEPTH = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // rx_byte[7:0], read_offset[16:8], zero pad
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // frame_type[7:0], payload_length[15:8],
                                   // frame_offset[24:16], read_value[32:25], pad
    output logic        m_tuser,   // result_kind
    output logic        m_tlast,   // last_of_run
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import slxed_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    res_t  res;

    assign cfg_ready = aresetn;

    slxed_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    slxed_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_byte   (s_tdata[7:0]),
        .in_offset (s_tdata[16:8]),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_res   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

    assign m_tdata = {7'd0, res.read_value, res.frame_offset,
                      res.payload_length, res.frame_type};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule
